// ===== rtl/event_ht_met_bjet_summer_assert.svh =====
// ----------------------------------------------------------------------------
// event summer assertion macros
// concurrent assertion helpers used by the event summer rtl
// ----------------------------------------------------------------------------
`ifndef EVENT_HT_MET_BJET_SUMMER_ASSERT_SVH
`define EVENT_HT_MET_BJET_SUMMER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define EHMBS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define EHMBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define EHMBS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define EHMBS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/ehmbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event summer package
// payload types, register indexes and fixed widths of the event summer
// ----------------------------------------------------------------------------
package ehmbs_pkg;

   localparam int MOMENTUM_WIDTH = 20;
   localparam int PT_WIDTH       = 20;
   localparam int HT_WIDTH       = 26;
   localparam int MET_WIDTH      = 20;
   localparam int BJET_WIDTH     = 8;
   localparam int COUNT_WIDTH    = 32;
   localparam int BTAG_WIDTH     = 16;
   localparam int CSR_DATA_WIDTH = 20;

   localparam logic [HT_WIDTH-1:0]   HT_MAX   = '1;
   localparam logic [BJET_WIDTH-1:0] BJET_MAX = '1;

   localparam logic [PT_WIDTH-1:0]         JET_PT_THRESHOLD_RESET = 20'd480;
   localparam logic signed [BTAG_WIDTH-1:0] BTAG_THRESHOLD_RESET  = 16'sd538;

   typedef enum logic [1:0] {
      KIND_JET      = 2'd0,
      KIND_ELECTRON = 2'd1,
      KIND_MUON     = 2'd2,
      KIND_MET      = 2'd3
   } object_kind_type;

   typedef enum logic {
      CSR_JET_PT_THRESHOLD = 1'b0,
      CSR_BTAG_THRESHOLD   = 1'b1
   } csr_index_type;

   typedef struct packed {
      object_kind_type                 object_kind;
      logic signed [MOMENTUM_WIDTH-1:0] mom_x;
      logic signed [MOMENTUM_WIDTH-1:0] mom_y;
      logic signed [BTAG_WIDTH-1:0]     btag_score;
      logic                             trigger_fired;
      logic                             last_in_event;
   } req_payload_type;

   typedef struct packed {
      logic [PT_WIDTH-1:0]    object_pt;
      logic                   event_done;
      logic                   event_passed;
      logic [HT_WIDTH-1:0]    ht_sum;
      logic [MET_WIDTH-1:0]   met_magnitude;
      logic [BJET_WIDTH-1:0]  bjet_count;
      logic [COUNT_WIDTH-1:0] events_seen;
   } rsp_payload_type;

endpackage

// ===== rtl/event_ht_met_bjet_summer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event ht, met and b-jet summer
// per-object transverse momentum with per-event ht, met and b-jet totals
// ----------------------------------------------------------------------------
// usage
//   req_*  : one physics object per request, valid/ready handshake
//   rsp_*  : one result per request, in order, valid/ready handshake
//   csr_*  : register writes (jet pt cut, b-tag cut); make them only while idle, the block does not enforce it
// sequence
//   a request is taken only when the sequencer is idle; after acceptance the
//   object passes the shared multiplier (px squared, then py squared added),
//   the bit-per-cycle square root and a final step that folds the momentum
//   into the totals and loads the output register; a new object is taken
//   only once the previous one has left that final step
// stalls
//   the result sits in an output register; a new request is taken while it
//   waits, and the sequencer holds in its final step until the register frees
// reset
//   synchronous, active high: thresholds return to 30 GeV and 2.1, all
//   accumulators and the event counter clear, no result is pending
// ----------------------------------------------------------------------------
module event_ht_met_bjet_summer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  ehmbs_pkg::req_payload_type       req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output ehmbs_pkg::rsp_payload_type       rsp_payload,
   input  logic                             csr_we,
   input  ehmbs_pkg::csr_index_type         csr_index,
   input  logic [ehmbs_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);

   import ehmbs_pkg::*;

`include "event_ht_met_bjet_summer_assert.svh"

   localparam int MW         = MOMENTUM_WIDTH;
   localparam int SQ_WIDTH   = 2 * MW;
   localparam int STEP_WIDTH = $clog2(MW);
   localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(MW - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_ROOT,
      ST_FINISH
   } state_type;

   // sequencer and datapath registers
   state_type                state_ff, state_in;
   logic [STEP_WIDTH-1:0]    step_ff, step_in;
   logic [MW-1:0]            mag_x_ff, mag_x_in;
   logic [MW-1:0]            mag_y_ff, mag_y_in;
   logic [SQ_WIDTH-1:0]      rad_ff, rad_in;       // radicand, shifted out two bits a step
   logic [MW+1:0]            rem_ff, rem_in;       // partial remainder of the root
   logic [MW-1:0]            root_ff, root_in;
   object_kind_type          kind_ff, kind_in;
   logic signed [BTAG_WIDTH-1:0] btag_ff, btag_in;
   logic                     trig_ff, trig_in;
   logic                     last_ff, last_in;

   // thresholds
   logic [PT_WIDTH-1:0]          jet_thr_ff, jet_thr_in;
   logic signed [BTAG_WIDTH-1:0] btag_thr_ff, btag_thr_in;

   // event accumulators
   logic [HT_WIDTH-1:0]    ht_acc_ff, ht_acc_in;
   logic [BJET_WIDTH-1:0]  bjet_acc_ff, bjet_acc_in;
   logic [MET_WIDTH-1:0]   met_hold_ff, met_hold_in;
   logic [COUNT_WIDTH-1:0] event_counter_ff, event_counter_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_payload_ff, rsp_payload_in;

   // shared multiplier and root step
   logic [MW-1:0]          mul_operand;
   logic [SQ_WIDTH-1:0]    mul_product;
   logic [MW+1:0]          rem_shifted;
   logic [MW+1:0]          trial;
   logic                   trial_fits;

   // totals update
   logic [HT_WIDTH:0]      ht_wide;
   logic [HT_WIDTH-1:0]    ht_next;
   logic [BJET_WIDTH-1:0]  bjet_next;
   logic [MET_WIDTH-1:0]   met_next;
   logic [COUNT_WIDTH-1:0] count_next;
   logic                   is_bjet;
   logic                   out_free;

   function automatic logic [MW-1:0] abs_mom(input logic signed [MW-1:0] v);
      // most negative value maps to 2^(MW-1), which fits unsigned
      abs_mom = v[MW-1] ? (~v + 1'b1) : v;
   endfunction

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign out_free    = !rsp_valid_ff || rsp_ready;

   // one multiplier, x then y
   assign mul_operand = (state_ff == ST_SQ_X) ? mag_x_ff : mag_y_ff;
   assign mul_product = SQ_WIDTH'(mul_operand) * SQ_WIDTH'(mul_operand);

   // restoring root step: remainder fits MW bits before the shift
   assign rem_shifted = {rem_ff[MW-1:0], rad_ff[SQ_WIDTH-1 -: 2]};
   assign trial       = {root_ff, 2'b01};
   assign trial_fits  = (rem_shifted >= trial);

   // totals with this object folded in
   always_comb begin
      ht_wide    = (HT_WIDTH+1)'(ht_acc_ff) + (HT_WIDTH+1)'(root_ff);
      is_bjet    = (kind_ff == KIND_JET) && (root_ff > jet_thr_ff)
                   && (btag_ff > btag_thr_ff) && (bjet_acc_ff != BJET_MAX);
      ht_next    = ht_acc_ff;
      bjet_next  = bjet_acc_ff;
      met_next   = met_hold_ff;
      if (kind_ff == KIND_MET) begin
         met_next = MET_WIDTH'(root_ff);
      end else begin
         ht_next = ht_wide[HT_WIDTH] ? HT_MAX : ht_wide[HT_WIDTH-1:0];
         if (is_bjet) begin
            bjet_next = bjet_acc_ff + 1'b1;
         end
      end
      count_next = event_counter_ff + 1'b1;
   end

   always_comb begin
      state_in         = state_ff;
      step_in          = step_ff;
      mag_x_in         = mag_x_ff;
      mag_y_in         = mag_y_ff;
      rad_in           = rad_ff;
      rem_in           = rem_ff;
      root_in          = root_ff;
      kind_in          = kind_ff;
      btag_in          = btag_ff;
      trig_in          = trig_ff;
      last_in          = last_ff;
      jet_thr_in       = jet_thr_ff;
      btag_thr_in      = btag_thr_ff;
      ht_acc_in        = ht_acc_ff;
      bjet_acc_in      = bjet_acc_ff;
      met_hold_in      = met_hold_ff;
      event_counter_in = event_counter_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_payload_in   = rsp_payload_ff;

      // register writes
      if (csr_we) begin
         case (csr_index)
            CSR_JET_PT_THRESHOLD: jet_thr_in  = csr_wdata[PT_WIDTH-1:0];
            CSR_BTAG_THRESHOLD:   btag_thr_in = csr_wdata[BTAG_WIDTH-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mag_x_in = abs_mom(req_payload.mom_x);
               mag_y_in = abs_mom(req_payload.mom_y);
               kind_in  = req_payload.object_kind;
               btag_in  = req_payload.btag_score;
               trig_in  = req_payload.trigger_fired;
               last_in  = req_payload.last_in_event;
               state_in = ST_SQ_X;
            end
         end
         ST_SQ_X: begin
            rad_in   = mul_product;
            state_in = ST_SQ_Y;
         end
         ST_SQ_Y: begin
            rad_in   = rad_ff + mul_product;
            rem_in   = '0;
            root_in  = '0;
            step_in  = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            rad_in = {rad_ff[SQ_WIDTH-3:0], 2'b00};
            if (trial_fits) begin
               rem_in  = rem_shifted - trial;
               root_in = {root_ff[MW-2:0], 1'b1};
            end else begin
               rem_in  = rem_shifted;
               root_in = {root_ff[MW-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // wait here while an earlier result is still unread
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_payload_in           = '0;
               rsp_payload_in.object_pt = PT_WIDTH'(root_ff);
               if (last_ff) begin
                  rsp_payload_in.event_done    = 1'b1;
                  rsp_payload_in.event_passed  = trig_ff;
                  rsp_payload_in.ht_sum        = ht_next;
                  rsp_payload_in.met_magnitude = met_next;
                  rsp_payload_in.bjet_count    = bjet_next;
                  rsp_payload_in.events_seen   = count_next;
                  event_counter_in             = count_next;
                  ht_acc_in                    = '0;
                  bjet_acc_in                  = '0;
                  met_hold_in                  = '0;
               end else begin
                  ht_acc_in   = ht_next;
                  bjet_acc_in = bjet_next;
                  met_hold_in = met_next;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         step_ff          <= '0;
         jet_thr_ff       <= JET_PT_THRESHOLD_RESET;
         btag_thr_ff      <= BTAG_THRESHOLD_RESET;
         ht_acc_ff        <= '0;
         bjet_acc_ff      <= '0;
         met_hold_ff      <= '0;
         event_counter_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         step_ff          <= step_in;
         jet_thr_ff       <= jet_thr_in;
         btag_thr_ff      <= btag_thr_in;
         ht_acc_ff        <= ht_acc_in;
         bjet_acc_ff      <= bjet_acc_in;
         met_hold_ff      <= met_hold_in;
         event_counter_ff <= event_counter_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      mag_x_ff       <= mag_x_in;
      mag_y_ff       <= mag_y_in;
      rad_ff         <= rad_in;
      rem_ff         <= rem_in;
      root_ff        <= root_in;
      kind_ff        <= kind_in;
      btag_ff        <= btag_in;
      trig_ff        <= trig_in;
      last_ff        <= last_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // a taken request keeps the block busy on the next cycle
   `EHMBS_ASSERT_NEXT(busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // results that do not close an event carry no totals
   `EHMBS_ASSERT_IMPL(no_totals_mid_event, clock, reset,
      rsp_valid && !rsp_payload.event_done,
      rsp_payload.ht_sum == '0 && rsp_payload.bjet_count == '0 && rsp_payload.events_seen == '0)

   // a pending end-of-event result agrees with the event counter
   `EHMBS_ASSERT_IMPL(count_matches_result, clock, reset,
      rsp_valid && rsp_payload.event_done, rsp_payload.events_seen == event_counter_ff)

endmodule

// ===== dv/tb_event_ht_met_bjet_summer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event summer testbench
// sends physics objects through the event summer under several cut settings
// and checks each result, field by field, against a model of the per-object
// pt and of the per-event ht, met, b-jet and event totals
// ----------------------------------------------------------------------------
module tb_event_ht_met_bjet_summer;
   import ehmbs_pkg::*;

   localparam int CLOCK_PERIOD    = 8;
   localparam int RESET_CYCLES    = 10;
   localparam int IDLE_PERCENT    = 38;
   localparam int ITEMS_PER_PHASE = 320;
   localparam int PHASE_COUNT     = 5;
   localparam int QUIET_PHASE     = 3;
   localparam int DRAIN_LIMIT     = 2000;
   localparam int SETTLE_CYCLES   = 30;

   // model of the summer: per-object pt plus the running event totals
   class event_scoreboard;
      logic [PT_WIDTH-1:0]          jet_cut     = JET_PT_THRESHOLD_RESET;
      logic signed [BTAG_WIDTH-1:0] btag_cut    = BTAG_THRESHOLD_RESET;
      logic [HT_WIDTH-1:0]          ht_total    = '0;
      logic [BJET_WIDTH-1:0]        bjet_total  = '0;
      logic [MET_WIDTH-1:0]         met_latest  = '0;
      logic [COUNT_WIDTH-1:0]       event_total = '0;
      rsp_payload_type              expected_results[$];
      int unsigned mismatches      = 0;
      int unsigned requests_seen   = 0;
      int unsigned results_checked = 0;
      int unsigned cut_writes      = 0;

      function int unsigned pending();
         return expected_results.size();
      endfunction

      function void set_register(input csr_index_type idx,
                                 input logic [CSR_DATA_WIDTH-1:0] data);
         case (idx)
            CSR_JET_PT_THRESHOLD: jet_cut = data[PT_WIDTH-1:0];
            CSR_BTAG_THRESHOLD:   btag_cut = data[BTAG_WIDTH-1:0];
            default: ;
         endcase
         cut_writes++;
      endfunction

      function logic [MOMENTUM_WIDTH-1:0] abs_momentum(
            input logic [MOMENTUM_WIDTH-1:0] v);
         return v[MOMENTUM_WIDTH-1] ? (~v + 1'b1) : v;
      endfunction

      function logic [63:0] floor_sqrt(input logic [63:0] n);
         logic [63:0] root;
         logic [63:0] probe;
         logic [63:0] rest;
         root  = '0;
         probe = 64'd1 << 62;
         rest  = n;
         while (probe > rest) probe = probe >> 2;
         while (probe != 0) begin
            if (rest >= root + probe) begin
               rest = rest - (root + probe);
               root = (root >> 1) + probe;
            end else begin
               root = root >> 1;
            end
            probe = probe >> 2;
         end
         return root;
      endfunction

      function void note_request(input req_payload_type item);
         rsp_payload_type               want;
         logic [MOMENTUM_WIDTH-1:0]     ax;
         logic [MOMENTUM_WIDTH-1:0]     ay;
         logic [63:0]                   pt;
         logic [HT_WIDTH:0]             ht_next;
         ax = abs_momentum(item.mom_x);
         ay = abs_momentum(item.mom_y);
         pt = floor_sqrt(64'(ax) * 64'(ax) + 64'(ay) * 64'(ay));
         if (pt > 64'({MOMENTUM_WIDTH{1'b1}})) pt = 64'({MOMENTUM_WIDTH{1'b1}});
         if (item.object_kind == KIND_MET) begin
            met_latest = pt[MET_WIDTH-1:0];
         end else begin
            ht_next  = {1'b0, ht_total} + pt[HT_WIDTH:0];
            ht_total = (ht_next > {1'b0, HT_MAX}) ? HT_MAX : ht_next[HT_WIDTH-1:0];
            if (item.object_kind == KIND_JET && pt > 64'(jet_cut) &&
                $signed(item.btag_score) > $signed(btag_cut) && bjet_total != BJET_MAX)
               bjet_total++;
         end
         want = '0;
         want.object_pt = pt[PT_WIDTH-1:0];
         if (item.last_in_event) begin
            event_total++;
            want.event_done    = 1'b1;
            want.event_passed  = item.trigger_fired;
            want.ht_sum        = ht_total;
            want.met_magnitude = met_latest;
            want.bjet_count    = bjet_total;
            want.events_seen   = event_total;
            ht_total   = '0;
            bjet_total = '0;
            met_latest = '0;
         end
         expected_results.push_back(want);
         requests_seen++;
      endfunction

      task report_mismatch(input string msg);
         mismatches++;
         $display("mismatch at %0t ns, result %0d: %s", $time, results_checked, msg);
      endtask

      task compare_field(input string name, input logic [31:0] got,
                         input logic [31:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
      endtask

      task check_result(input rsp_payload_type got);
         rsp_payload_type want;
         if (expected_results.size() == 0) begin
            report_mismatch("result with no request outstanding");
         end else begin
            want = expected_results.pop_front();
            compare_field("object_pt", 32'(got.object_pt), 32'(want.object_pt));
            compare_field("event_done", 32'(got.event_done), 32'(want.event_done));
            compare_field("event_passed", 32'(got.event_passed), 32'(want.event_passed));
            compare_field("ht_sum", 32'(got.ht_sum), 32'(want.ht_sum));
            compare_field("met_magnitude", 32'(got.met_magnitude),
                          32'(want.met_magnitude));
            compare_field("bjet_count", 32'(got.bjet_count), 32'(want.bjet_count));
            compare_field("events_seen", got.events_seen, want.events_seen);
         end
         results_checked++;
      endtask

      task close_out();
         if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_results.size()));
      endtask
   endclass

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   req_payload_type            req_payload;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   rsp_payload_type            rsp_payload;
   logic                       csr_we;
   csr_index_type              csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   event_scoreboard sb;
   // set during one phase to give a long stretch with no idling on either side
   bit quiet = 1'b0;

   event_ht_met_bjet_summer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // result side back-pressure, random unless in the quiet phase
   always @(posedge clock) begin
      rsp_ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // every result taken at an edge goes to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_payload);
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #(5_000_000);
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic req_payload_type make_request(input object_kind_type kind,
         input int x, input int y, input int tag, input logic trig, input logic last);
      req_payload_type item;
      item.object_kind   = kind;
      item.mom_x         = x[MOMENTUM_WIDTH-1:0];
      item.mom_y         = y[MOMENTUM_WIDTH-1:0];
      item.btag_score    = tag[BTAG_WIDTH-1:0];
      item.trigger_fired = trig;
      item.last_in_event = last;
      return item;
   endfunction

   // momentum mix: full scale, small, mid range and anything
   function automatic int random_momentum();
      int v;
      case ($urandom_range(7))
         0:       v = $urandom_range(1) ? -524288 : 524287;
         1:       v = int'($urandom_range(2000)) - 1000;
         2, 3:    v = int'($urandom_range(65535)) - 32768;
         default: v = int'($urandom());
      endcase
      return v;
   endfunction

   function automatic req_payload_type random_request(input logic last);
      object_kind_type kind;
      int              x;
      int              y;
      int              tag;
      int              cut_pt;
      case ($urandom_range(19))
         0, 1, 2, 3, 4, 5, 6, 7, 8: kind = KIND_JET;
         9, 10, 11:                 kind = KIND_ELECTRON;
         12, 13, 14:                kind = KIND_MUON;
         default:                   kind = KIND_MET;
      endcase
      if ($urandom_range(4) == 0) begin
         // pt lands on, just under or just over the jet cut
         cut_pt = int'(sb.jet_cut) + int'($urandom_range(2)) - 1;
         x = $urandom_range(1) ? cut_pt : -cut_pt;
         y = 0;
      end else begin
         x = random_momentum();
         y = random_momentum();
      end
      case ($urandom_range(3))
         0:       tag = int'(sb.btag_cut) + int'($urandom_range(2)) - 1;
         1:       tag = $urandom_range(1) ? -32768 : 32767;
         default: tag = int'($urandom());
      endcase
      return make_request(kind, x, y, tag, 1'($urandom()), last);
   endfunction

   // one request with an optional idle gap ahead of it, held until taken
   task automatic push_request(input req_payload_type item);
      if (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 28)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      sb.note_request(item);
   endtask

   // sender stops until every outstanding result is back
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx,
                                 input logic [CSR_DATA_WIDTH-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.set_register(idx, data);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // cut settings per phase: reset values, both extremes, random, back again
   task automatic apply_setting(input int phase);
      logic [PT_WIDTH-1:0]          jet_value;
      logic signed [BTAG_WIDTH-1:0] tag_value;
      case (phase)
         1: begin
            jet_value = '0;
            tag_value = 16'sh8000;
         end
         2: begin
            jet_value = '1;
            tag_value = 16'sh7fff;
         end
         3: begin
            jet_value = PT_WIDTH'($urandom_range(3000));
            tag_value = BTAG_WIDTH'($urandom());
         end
         default: begin
            jet_value = JET_PT_THRESHOLD_RESET;
            tag_value = BTAG_THRESHOLD_RESET;
         end
      endcase
      write_register(CSR_JET_PT_THRESHOLD, jet_value);
      // upper data bits above the b-tag field are don't-care, so randomise them
      write_register(CSR_BTAG_THRESHOLD,
                     {(CSR_DATA_WIDTH - BTAG_WIDTH)'($urandom()), tag_value});
   endtask

   // directed objects under the reset cuts of 480 and 538
   task automatic run_directed();
      // pt equal to the jet cut does not count, nor does b-tag equal to its cut
      push_request(make_request(KIND_JET, 480, 0, 539, 1'b0, 1'b0));
      push_request(make_request(KIND_JET, 481, 0, 538, 1'b0, 1'b0));
      push_request(make_request(KIND_JET, -481, 0, 539, 1'b0, 1'b0));
      // most negative and most positive momenta, largest possible pt
      push_request(make_request(KIND_ELECTRON, -524288, -524288, 0, 1'b0, 1'b0));
      push_request(make_request(KIND_MUON, 524287, 524287, -1, 1'b0, 1'b0));
      // two met vectors, the second one is kept; trigger not fired
      push_request(make_request(KIND_MET, 3, 4, 0, 1'b1, 1'b0));
      push_request(make_request(KIND_MET, -300, 400, 0, 1'b0, 1'b1));
      // single zero jet, no met in the event
      push_request(make_request(KIND_JET, 0, 0, -32768, 1'b1, 1'b1));
      // met only event with a most negative component
      push_request(make_request(KIND_MET, -524288, 0, 32767, 1'b1, 1'b1));
      // mixed event, b-tag ignored on leptons
      push_request(make_request(KIND_JET, -1, 1, 32767, 1'b0, 1'b0));
      push_request(make_request(KIND_ELECTRON, 0, -524288, 32767, 1'b0, 1'b0));
      push_request(make_request(KIND_MUON, 524287, 0, 32767, 1'b0, 1'b0));
      push_request(make_request(KIND_JET, 600, -800, 32767, 1'b1, 1'b1));
      // met first, then overwritten, jet closes the event
      push_request(make_request(KIND_MET, 100, 100, 0, 1'b0, 1'b0));
      push_request(make_request(KIND_MET, -7, -24, 0, 1'b0, 1'b0));
      push_request(make_request(KIND_JET, 5000, 5000, 1000, 1'b1, 1'b1));
   endtask

   // long events that drive ht and the b-jet count into saturation
   task automatic run_saturation_events();
      int k;
      for (k = 0; k < 100; k++)
         push_request(make_request((k % 3 == 0) ? KIND_JET : KIND_MUON,
                                   -524288, 524287, 0, 1'b1, k == 99));
      for (k = 0; k < 260; k++)
         push_request(make_request(KIND_JET, 524287, -524288, 32767, k[0], k == 259));
   endtask

   // random events, mostly short, some long, a few cut short at random
   task automatic run_random_events(input int item_budget);
      int sent;
      int len;
      int k;
      sent = 0;
      while (sent < item_budget) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 8);
         for (k = 0; k < len; k++) begin
            push_request(random_request(k == len - 1 || $urandom_range(19) == 0));
            // now and then let the pipe run dry mid event
            if ($urandom_range(49) == 0) hold_until_drained();
            sent++;
         end
      end
   endtask

   initial begin
      int phase;
      int n;
      sb = new;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_we      <= 1'b0;
      csr_index   <= CSR_JET_PT_THRESHOLD;
      csr_wdata   <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      run_saturation_events();
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         // cuts change only with nothing in flight
         if (phase > 0) begin
            hold_until_drained();
            apply_setting(phase);
         end
         quiet = (phase == QUIET_PHASE);
         run_random_events(ITEMS_PER_PHASE);
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      // wait out the remaining results, then let any late result show up
      for (n = 0; n < DRAIN_LIMIT && sb.pending() != 0; n++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      sb.close_out();

      $display("summary: %0d objects over %0d events, %0d results compared",
               sb.requests_seen, sb.event_total, sb.results_checked);
      $display("summary: %0d cut writes, extremes and random values, with stalls",
               sb.cut_writes);
      if (sb.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
